>>> rtl/core/xrng_pkg.sv
// Shared types and constants for the xoshiro256+ generator core.
package xrng_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int WORD_COUNT = 4;
    localparam int WORD_IDX_W = $clog2(WORD_COUNT);
    localparam int FRAC_W     = 53;
    localparam int FRAC_LSB   = WORD_W - FRAC_W;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

    localparam int MIX_SHIFT_1 = 30;
    localparam int MIX_SHIFT_2 = 27;
    localparam int MIX_SHIFT_3 = 31;
    localparam int UPD_SHIFT   = 17;
    localparam int UPD_ROTATE  = 45;

    typedef enum logic {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_GAMMA,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_XS27,
        DP_STORE,
        DP_DRAW
    } t_dp_op;

    typedef struct packed {
        t_dp_op                op;
        logic                  seed_zero;
        logic                  mul_sel;
        logic [WORD_IDX_W-1:0] word;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_GAMMA,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_XS27,
        ST_STORE
    } t_state;

endpackage

>>> rtl/core/xrng_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface xrng_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [xrng_pkg::WORD_W-1:0] seed;

    modport source (output valid, output op, output seed, input ready);
    modport sink   (input valid, input op, input seed, output ready);
endinterface

interface xrng_out_if;
    logic                       valid;
    logic                       ready;
    logic [xrng_pkg::FRAC_W-1:0] fraction;

    modport source (output valid, output fraction, input ready);
    modport sink   (input valid, input fraction, output ready);
endinterface

>>> rtl/core/xoshiro256_plus_generator_core.sv
// Top level of the xoshiro256+ generator core with SplitMix64 seeding.
// The core keeps four 64-bit state words. When a draw beat (op = 1) is taken,
// the top 53 bits of word0 + word3 land in the result register as an
// unsigned fraction with 53 fraction bits, and the state advances by the
// xoshiro256+ update in the same cycle, so draws run at one beat per cycle for
// as long as the result side keeps taking them. A reseed beat (op = 0) gives no
// result; the input is held off after it is taken while four SplitMix64 steps
// fill the state words one after another. Each step uses the single shared
// 32x32 multiplier, which forms each wrapped 64-bit product in three passes,
// two products per step. Straight after reset the core runs the same expansion
// with a seed of zero and keeps ready low while it runs; afterwards it behaves
// exactly as if seed zero had just been written. A draw beat is accepted while
// an earlier result still waits only in the cycle that result is taken.
module xoshiro256_plus_generator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xrng_in_if.sink    i_in,
    xrng_out_if.source o_out
);
    import xrng_pkg::*;

    t_dp_cmd           dp_cmd;
    logic              in_ready;
    logic              out_valid;
    logic [FRAC_W-1:0] fraction;

    // The controller owns the handshakes and the seed expansion sequence.
    xrng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the state words and the result register.
    xrng_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .i_seed     (i_in.seed),
        .o_fraction (fraction)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.fraction = fraction;

endmodule

>>> rtl/core/xrng_dp.sv
// Datapath: state words, seed expansion registers, shared multiplier, draw logic.
module xrng_dp (
    input  logic                        i_clk,
    input  xrng_pkg::t_dp_cmd           i_cmd,
    input  logic [xrng_pkg::WORD_W-1:0] i_seed,
    output logic [xrng_pkg::FRAC_W-1:0] o_fraction
);
    import xrng_pkg::*;

    logic [WORD_W-1:0] r_words [WORD_COUNT];
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_z;
    logic [WORD_W-1:0] r_acc;
    logic [FRAC_W-1:0] r_fraction;

    logic [WORD_W-1:0] n_seed;
    logic [WORD_W-1:0] mul_const;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_p;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W-1:0] n2a;
    logic [WORD_W-1:0] n3a;
    logic [WORD_W-1:0] n1;
    logic [WORD_W-1:0] n0;

    // One 32x32 multiplier builds the wrapped 64-bit product in three passes.
    always_comb begin
        n_seed    = r_seed + GOLDEN_GAMMA;
        mul_const = i_cmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
        mul_a     = (i_cmd.op == DP_MUL1) ? r_z[WORD_W-1:HALF_W] : r_z[HALF_W-1:0];
        mul_b     = (i_cmd.op == DP_MUL2) ? mul_const[WORD_W-1:HALF_W]
                                          : mul_const[HALF_W-1:0];
        mul_p     = WORD_W'(mul_a) * WORD_W'(mul_b);
        sum       = r_words[0] + r_words[3];
        shifted   = r_words[1] << UPD_SHIFT;
        n2a       = r_words[2] ^ r_words[0];
        n3a       = r_words[3] ^ r_words[1];
        n1        = r_words[1] ^ n2a;
        n0        = r_words[0] ^ n3a;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_seed <= i_cmd.seed_zero ? '0 : i_seed;
            end
            DP_GAMMA: begin
                r_seed <= n_seed;
                r_z    <= n_seed ^ (n_seed >> MIX_SHIFT_1);
            end
            DP_MUL0: begin
                r_acc <= mul_p;
            end
            DP_MUL1, DP_MUL2: begin
                r_acc[WORD_W-1:HALF_W] <= r_acc[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
            end
            DP_XS27: begin
                r_z <= r_acc ^ (r_acc >> MIX_SHIFT_2);
            end
            DP_STORE: begin
                r_words[i_cmd.word] <= r_acc ^ (r_acc >> MIX_SHIFT_3);
            end
            DP_DRAW: begin
                r_fraction <= sum[WORD_W-1:FRAC_LSB];
                r_words[0] <= n0;
                r_words[1] <= n1;
                r_words[2] <= n2a ^ shifted;
                r_words[3] <= {n3a[WORD_W-UPD_ROTATE-1:0], n3a[WORD_W-1:WORD_W-UPD_ROTATE]};
            end
            default: begin
            end
        endcase
    end

    assign o_fraction = r_fraction;

endmodule

>>> rtl/core/xrng_ctrl.sv
// Controller: handshakes and the sequencer for seed expansion.
module xrng_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output xrng_pkg::t_dp_cmd o_cmd
);
    import xrng_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic                  r_round;
    logic                  n_round;
    logic [WORD_IDX_W-1:0] r_word;
    logic [WORD_IDX_W-1:0] n_word;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_round     <= 1'b0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_round       = r_round;
        n_word        = r_word;
        o_in_ready    = 1'b0;
        accept        = 1'b0;
        o_cmd.op        = DP_NONE;
        o_cmd.seed_zero = 1'b0;
        o_cmd.mul_sel   = r_round;
        o_cmd.word      = r_word;
        case (r_state)
            ST_INIT: begin
                o_cmd.op        = DP_LOAD;
                o_cmd.seed_zero = 1'b1;
                n_word          = '0;
                n_state         = ST_GAMMA;
            end
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                accept     = o_in_ready && i_in_valid;
                if (accept) begin
                    if (i_in_op == OP_DRAW) begin
                        o_cmd.op = DP_DRAW;
                    end else begin
                        o_cmd.op = DP_LOAD;
                        n_word   = '0;
                        n_state  = ST_GAMMA;
                    end
                end
            end
            ST_GAMMA: begin
                o_cmd.op = DP_GAMMA;
                n_round  = 1'b0;
                n_state  = ST_MUL0;
            end
            ST_MUL0: begin
                o_cmd.op = DP_MUL0;
                n_state  = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.op = DP_MUL1;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.op = DP_MUL2;
                n_state  = r_round ? ST_STORE : ST_XS27;
            end
            ST_XS27: begin
                o_cmd.op = DP_XS27;
                n_round  = 1'b1;
                n_state  = ST_MUL0;
            end
            ST_STORE: begin
                o_cmd.op = DP_STORE;
                if (r_word == WORD_IDX_W'(WORD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_state = ST_GAMMA;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase

        if (accept && i_in_op == OP_DRAW) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
